// ===== rtl/core/adcr_pkg.sv =====
// adcr_pkg: shared types and fixed widths of the averaged deadband change reporter
// no dependencies; used by adcr_out_if, adcr_decide and the top level
package adcr_pkg;

  localparam int unsigned TOL_BITS       = 10;
  localparam int unsigned RELOAD_BITS    = 8;
  localparam int unsigned GROUP_BITS     = 8;
  localparam int unsigned POSITION_BITS  = 10;
  localparam int unsigned CFG_DATA_BITS  = 10;
  localparam int unsigned CFG_INDEX_BITS = 2;

  localparam logic [TOL_BITS-1:0]    TOL_RESET    = 10'd8;
  localparam logic [RELOAD_BITS-1:0] RELOAD_RESET = 8'd3;
  localparam logic [GROUP_BITS-1:0]  GROUP_RESET  = 8'd0;

  typedef logic [TOL_BITS-1:0]       tol_t;
  typedef logic [RELOAD_BITS-1:0]    reload_t;
  typedef logic [GROUP_BITS-1:0]     group_t;
  typedef logic [POSITION_BITS-1:0]  position_t;
  typedef logic [CFG_DATA_BITS-1:0]  cfg_data_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TOLERANCE = 2'd0,
    REG_RELOAD    = 2'd1,
    REG_GROUP_ID  = 2'd2
  } cfg_index_t;

  // decision of the update stage for one word
  typedef struct packed {
    logic      report;
    position_t position;
  } dec_t;

endpackage

// ===== rtl/core/adcr_if.sv =====
// adcr_in_if / adcr_out_if: valid-ready channels of the reporter
// depends on adcr_pkg for the result field types
interface adcr_in_if #(
  parameter int unsigned SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample_a;
  logic [SAMPLE_BITS-1:0] sample_b;
  logic [SAMPLE_BITS-1:0] sample_c;
  logic [SAMPLE_BITS-1:0] sample_d;

  modport source (output valid, sample_a, sample_b, sample_c, sample_d, input ready);
  modport sink   (input valid, sample_a, sample_b, sample_c, sample_d, output ready);
endinterface

interface adcr_out_if;
  logic                 valid;
  logic                 ready;
  adcr_pkg::group_t     report_group;
  adcr_pkg::position_t  position;

  modport source (output valid, report_group, position, input ready);
  modport sink   (input valid, report_group, position, output ready);
endinterface

// ===== rtl/core/adcr_front.sv =====
// adcr_front: sums the four samples and holds the average in the input register
// depends on nothing beyond its parameter
module adcr_front #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  logic                   drain,
  input  logic [SAMPLE_BITS-1:0] sample_a,
  input  logic [SAMPLE_BITS-1:0] sample_b,
  input  logic [SAMPLE_BITS-1:0] sample_c,
  input  logic [SAMPLE_BITS-1:0] sample_d,
  output logic                   avg_valid,
  output logic [SAMPLE_BITS-1:0] avg
);

  localparam int unsigned SUM_BITS = SAMPLE_BITS + 2;

  logic [SUM_BITS-1:0]    sum;
  logic                   valid_r, valid_nxt;
  logic [SAMPLE_BITS-1:0] avg_r;

  assign sum = SUM_BITS'(sample_a) + SUM_BITS'(sample_b)
             + SUM_BITS'(sample_c) + SUM_BITS'(sample_d);

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (drain) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // divide by four
  always_ff @(posedge clk) begin
    if (load) begin
      avg_r <= sum[SUM_BITS-1:2];
    end
  end

  assign avg_valid = valid_r;
  assign avg       = avg_r;

endmodule

// ===== rtl/core/adcr_decide.sv =====
// adcr_decide: deadband compare, countdown and last reported value
// depends on adcr_pkg for widths and the decision struct
module adcr_decide #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step,
  input  logic [SAMPLE_BITS-1:0]  avg,
  input  adcr_pkg::tol_t          tolerance,
  input  adcr_pkg::reload_t       reload,
  output adcr_pkg::dec_t          dec
);

  localparam int unsigned CMP_BITS =
    ((SAMPLE_BITS > adcr_pkg::TOL_BITS) ? SAMPLE_BITS : adcr_pkg::TOL_BITS) + 1;
  localparam int unsigned EXT_BITS =
    (SAMPLE_BITS > adcr_pkg::POSITION_BITS) ? SAMPLE_BITS : adcr_pkg::POSITION_BITS;

  logic [SAMPLE_BITS-1:0] last_r, last_nxt;
  adcr_pkg::reload_t      count_r, count_nxt;
  logic [CMP_BITS-1:0]    avg_w, last_w, tol_w;
  logic                   outside;
  logic [EXT_BITS-1:0]    avg_ext;

  assign avg_w  = CMP_BITS'(avg);
  assign last_w = CMP_BITS'(last_r);
  assign tol_w  = CMP_BITS'(tolerance);

  // bounds are inclusive, no wrap in the wider compare
  assign outside = (avg_w > last_w + tol_w) || (avg_w + tol_w < last_w);

  always_comb begin
    last_nxt  = last_r;
    count_nxt = count_r;
    if (step) begin
      if (count_r == '0) begin
        last_nxt  = avg;
        count_nxt = reload;
      end else if (outside) begin
        count_nxt = count_r - 1'b1;
      end else begin
        count_nxt = reload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      count_r <= '0;
    end else begin
      last_r  <= last_nxt;
      count_r <= count_nxt;
    end
  end

  assign avg_ext      = EXT_BITS'(avg);
  assign dec.report   = step && (count_r == '0);
  assign dec.position = avg_ext[adcr_pkg::POSITION_BITS-1:0];

endmodule

// ===== rtl/core/averaged_deadband_change_reporter.sv =====
// averaged_deadband_change_reporter: top level, config registers and result register
// depends on adcr_pkg, adcr_if, adcr_front and adcr_decide
//
//  channel | dir | handshake            | contents
//  in_if   | in  | valid / ready        | sample_a..sample_d, SAMPLE_BITS each
//  out_if  | out | valid / ready        | report_group, position
//  cfg_*   | in  | cfg_we, no wait      | cfg_index, cfg_wdata
//
//  one word per cycle unless out_if stalls; reports go via input and result registers
//  the rate is set by the input register feeding the deadband update
//  in_if.ready drops only while the input register holds a word and the result
//  register holds a report not yet taken
//  synchronous active-low reset: countdown zero, so the first word reports
module averaged_deadband_change_reporter #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  adcr_in_if.sink                       in_if,
  adcr_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [adcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  adcr_pkg::cfg_data_t           cfg_wdata
);

  // configuration registers
  adcr_pkg::tol_t    tol_r;
  adcr_pkg::reload_t reload_r;
  adcr_pkg::group_t  group_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= adcr_pkg::TOL_RESET;
      reload_r <= adcr_pkg::RELOAD_RESET;
      group_r  <= adcr_pkg::GROUP_RESET;
    end else if (cfg_we) begin
      unique case (adcr_pkg::cfg_index_t'(cfg_index))
        adcr_pkg::REG_TOLERANCE: tol_r    <= cfg_wdata[adcr_pkg::TOL_BITS-1:0];
        adcr_pkg::REG_RELOAD:    reload_r <= cfg_wdata[adcr_pkg::RELOAD_BITS-1:0];
        adcr_pkg::REG_GROUP_ID:  group_r  <= cfg_wdata[adcr_pkg::GROUP_BITS-1:0];
        default: ; // unknown index: write dropped
      endcase
    end
  end

  // pipeline control
  logic                   avg_valid;
  logic [SAMPLE_BITS-1:0] avg;
  logic                   advance;
  logic                   in_fire;
  adcr_pkg::dec_t         dec;

  logic                   out_valid_r, out_valid_nxt;
  adcr_pkg::group_t       out_group_r;
  adcr_pkg::position_t    out_pos_r;

  // the held word moves on whenever the result register is free or being emptied
  assign advance     = !out_valid_r || out_if.ready;
  assign in_if.ready = !avg_valid || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  adcr_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .drain     (advance),
    .sample_a  (in_if.sample_a),
    .sample_b  (in_if.sample_b),
    .sample_c  (in_if.sample_c),
    .sample_d  (in_if.sample_d),
    .avg_valid (avg_valid),
    .avg       (avg)
  );

  adcr_decide #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (avg_valid && advance),
    .avg       (avg),
    .tolerance (tol_r),
    .reload    (reload_r),
    .dec       (dec)
  );

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = dec.report;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.report) begin
      out_group_r <= group_r;
      out_pos_r   <= dec.position;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.report_group = out_group_r;
  assign out_if.position     = out_pos_r;

`ifndef SYNTHESIS
  // a report lands in the result register on the next cycle with its position
  a_report_lands: assert property (@(posedge clk) disable iff (!rst_n)
    dec.report |=> out_valid_r && (out_pos_r == $past(dec.position)))
    else $error("report not captured in result register");

  // input stalls only when both stages are full and the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> avg_valid && out_valid_r && !out_if.ready)
    else $error("input stalled without a blocked output");

  // a held word is never dropped: if it cannot advance it is still there next cycle
  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    (avg_valid && !advance) |=> avg_valid && $stable(avg))
    else $error("held word lost while stalled");
`endif

endmodule
